// File: rtl/ndf_pkg.sv
// Shared constants, types and helper functions of the nodata neighbour fill block.
package ndf_pkg;

    // Geometry and data widths.
    localparam int MAX_COLS        = 4096;
    localparam int SAMPLE_BITS     = 32;
    localparam int CELL_BITS       = 32;
    localparam int COL_BITS        = 13;
    localparam int ROW_BITS        = 21;
    localparam int COL_IDX_BITS    = $clog2(MAX_COLS);
    localparam int COUNT_BITS      = 33;
    localparam int STORE_ADDR_BITS = $clog2(MAX_COLS) + 2;
    localparam int SUM_BITS        = CELL_BITS + 3;
    localparam int NBR_CNT_BITS    = 4;
    localparam int NBR_IDX_BITS    = 3;
    localparam int DIV_STEP_BITS   = $clog2(SUM_BITS + 1);
    localparam int REM_BITS        = 3;

    // Configuration port.
    localparam int PADDR_BITS    = 4;
    localparam int APB_DATA_BITS = 32;

    // Index of the final neighbour in the scan.
    localparam logic [NBR_IDX_BITS-1:0] NBR_LAST = NBR_IDX_BITS'(7);

    // Register indexes, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_NODATA   = 2'd0,
        REG_NUM_COLS = 2'd1,
        REG_NUM_ROWS = 2'd2
    } reg_idx_t;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic signed [CELL_BITS-1:0] nodata;
        logic [COL_BITS-1:0]         cols;
        logic [ROW_BITS-1:0]         rows;
        logic [COUNT_BITS-1:0]       total;
        logic                        geom_wr;
    } cfg_t;

    // Direction of one neighbour relative to the centre cell.
    typedef struct packed {
        logic up;
        logic down;
        logic left;
        logic right;
    } nbr_dir_t;

    // Map a neighbour index to its direction.
    function automatic nbr_dir_t nbr_dir(input logic [NBR_IDX_BITS-1:0] idx);
        nbr_dir_t d;
        d = '0;
        case (idx)
            3'd0:    begin d.up = 1'b1;   d.left  = 1'b1; end
            3'd1:    begin d.up = 1'b1;                   end
            3'd2:    begin d.up = 1'b1;   d.right = 1'b1; end
            3'd3:    begin d.left = 1'b1;                 end
            3'd4:    begin d.right = 1'b1;                end
            3'd5:    begin d.down = 1'b1; d.left  = 1'b1; end
            3'd6:    begin d.down = 1'b1;                 end
            default: begin d.down = 1'b1; d.right = 1'b1; end
        endcase
        return d;
    endfunction

    // Column count saturated to one up to the maximum.
    function automatic logic [COL_BITS-1:0] eff_cols(input logic [COL_BITS-1:0] v);
        logic [COL_BITS-1:0] r;
        r = v;
        if (v == '0)
            r = COL_BITS'(1);
        else if (v > COL_BITS'(MAX_COLS))
            r = COL_BITS'(MAX_COLS);
        return r;
    endfunction

    // Row count with zero read as one.
    function automatic logic [ROW_BITS-1:0] eff_rows(input logic [ROW_BITS-1:0] v);
        return (v == '0) ? ROW_BITS'(1) : v;
    endfunction

    // Sign-extend the sample from its significant width.
    function automatic logic signed [CELL_BITS-1:0] sext_cell(input logic [CELL_BITS-1:0] v);
        logic signed [CELL_BITS-1:0] t;
        t = signed'(v << (CELL_BITS - SAMPLE_BITS));
        return t >>> (CELL_BITS - SAMPLE_BITS);
    endfunction

endpackage

// File: rtl/ndf_if.sv
// Stream interfaces for the input cells and the filled result cells.
interface ndf_cell_if;
    import ndf_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [CELL_BITS-1:0] sample;
    logic                        drain;

    modport source (output valid, output sample, output drain, input ready);
    modport sink   (input valid, input sample, input drain, output ready);
endinterface

interface ndf_result_if;
    import ndf_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [CELL_BITS-1:0] value;
    logic                        was_filled;
    logic                        last_cell;

    modport source (output valid, output value, output was_filled, output last_cell,
                    input ready);
    modport sink   (input valid, input value, input was_filled, input last_cell,
                    output ready);
endinterface

// File: rtl/ndf_store_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module ndf_store_ram #(
    parameter int ADDR_BITS = 14,
    parameter int DATA_BITS = 32
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

// File: rtl/ndf_mean_div.sv
// Restoring divider of the neighbour sum magnitude by the neighbour count, one bit a cycle.
module ndf_mean_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [ndf_pkg::SUM_BITS-1:0]        dividend,
    input  logic [ndf_pkg::NBR_CNT_BITS-1:0]    divisor,
    output logic                                done,
    output logic [ndf_pkg::CELL_BITS-1:0]       quotient
);
    import ndf_pkg::*;

    logic                      busy_reg, busy_next;
    logic [DIV_STEP_BITS-1:0]  step_reg, step_next;
    logic [SUM_BITS-1:0]       work_reg, work_next;
    logic [REM_BITS-1:0]       rem_reg, rem_next;
    logic [NBR_CNT_BITS-1:0]   dvs_reg, dvs_next;
    logic [NBR_CNT_BITS-1:0]   partial;
    logic [NBR_CNT_BITS-1:0]   diff;
    logic                      qbit;

    // One quotient bit: bring down the next dividend bit and try a subtraction.
    assign partial = {rem_reg, work_reg[SUM_BITS-1]};
    assign qbit    = (partial >= dvs_reg);
    assign diff    = partial - dvs_reg;

    assign done     = busy_reg && (step_reg == '0);
    assign quotient = work_reg[CELL_BITS-1:0];

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = DIV_STEP_BITS'(SUM_BITS);
            work_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (step_reg == '0)
                busy_next = 1'b0;
            else
            begin
                step_next = step_reg - DIV_STEP_BITS'(1);
                work_next = {work_reg[SUM_BITS-2:0], qbit};
                rem_next  = qbit ? diff[REM_BITS-1:0] : partial[REM_BITS-1:0];
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

endmodule

// File: rtl/ndf_apb_regs.sv
// Configuration registers behind an APB-style port, with the derived frame geometry.
module ndf_apb_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ndf_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [ndf_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [ndf_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready,
    output ndf_pkg::cfg_t                      cfg
);
    import ndf_pkg::*;

    logic [CELL_BITS-1:0]  nodata_reg, nodata_next;
    logic [COL_BITS-1:0]   cols_reg, cols_next;
    logic [ROW_BITS-1:0]   rows_reg, rows_next;
    logic [COL_BITS-1:0]   cols_eff_reg, cols_eff_next;
    logic [ROW_BITS-1:0]   rows_eff_reg, rows_eff_next;
    logic [COUNT_BITS-1:0] total_reg, total_next;
    logic                  wr;
    logic                  geom_wr;
    reg_idx_t              idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);

    // Register writes; a geometry write recomputes the cell count of a frame.
    always_comb
    begin
        nodata_next   = nodata_reg;
        cols_next     = cols_reg;
        rows_next     = rows_reg;
        cols_eff_next = cols_eff_reg;
        rows_eff_next = rows_eff_reg;
        geom_wr       = 1'b0;
        if (wr)
        begin
            case (idx)
                REG_NODATA:
                    nodata_next = pwdata[CELL_BITS-1:0];
                REG_NUM_COLS:
                begin
                    cols_next     = pwdata[COL_BITS-1:0];
                    cols_eff_next = eff_cols(pwdata[COL_BITS-1:0]);
                    geom_wr       = 1'b1;
                end
                REG_NUM_ROWS:
                begin
                    rows_next     = pwdata[ROW_BITS-1:0];
                    rows_eff_next = eff_rows(pwdata[ROW_BITS-1:0]);
                    geom_wr       = 1'b1;
                end
                default:
                    geom_wr = 1'b0;
            endcase
        end
        total_next = COUNT_BITS'(rows_eff_next) * COUNT_BITS'(cols_eff_next);
    end

    // Read-back of the written values.
    always_comb
    begin
        case (idx)
            REG_NODATA:   prdata = nodata_reg;
            REG_NUM_COLS: prdata = APB_DATA_BITS'(cols_reg);
            REG_NUM_ROWS: prdata = APB_DATA_BITS'(rows_reg);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodata_reg   <= '0;
            cols_reg     <= COL_BITS'(MAX_COLS);
            rows_reg     <= ROW_BITS'(1);
            cols_eff_reg <= COL_BITS'(MAX_COLS);
            rows_eff_reg <= ROW_BITS'(1);
            total_reg    <= COUNT_BITS'(MAX_COLS);
        end
        else
        begin
            nodata_reg   <= nodata_next;
            cols_reg     <= cols_next;
            rows_reg     <= rows_next;
            cols_eff_reg <= cols_eff_next;
            rows_eff_reg <= rows_eff_next;
            if (geom_wr)
                total_reg <= total_next;
        end
    end

    assign cfg.nodata  = sext_cell(nodata_reg);
    assign cfg.cols    = cols_eff_reg;
    assign cfg.rows    = rows_eff_reg;
    assign cfg.total   = total_reg;
    assign cfg.geom_wr = geom_wr;

endmodule

// File: rtl/raster_nodata_neighbor_fill.sv
// Top level: raster-order nodata fill with a 3x3 neighbour mean over a circular cell store.
//
//  Channel  Role    Handshake          Payload
//  cells    sink    valid/ready        sample (s32), drain (1)
//  result   source  valid/ready        value (s32), was_filled (1), last_cell (1)
//  apb      slave   psel/penable/wr    nodata @0, num_cols @4, num_rows @8
//
// One request is handled at a time. A request that yields no cell at most writes the store; one
// that yields a valid cell passes the store write (none when draining), centre read and result.
// A nodata cell then reads the in-grid neighbours, skips off-grid ones, ends the scan and, if a
// valid neighbour exists, runs the bit-serial mean divider. The result sits in an output
// register, so a stalled sink holds only the next request that produces a cell. Reset clears
// the control state; the store needs no clearing since only cells of the current frame are read.
module raster_nodata_neighbor_fill (
    input  logic                               clk,
    input  logic                               rst_n,
    ndf_cell_if.sink                           cells,
    ndf_result_if.source                       result,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ndf_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [ndf_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [ndf_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready
);
    import ndf_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CTR  = 7'b0000010,
        S_NRD  = 7'b0000100,
        S_NEV  = 7'b0001000,
        S_FIN  = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    cfg_t cfg;

    state_t                       state_reg, state_next;
    logic [COUNT_BITS-1:0]        in_pos_reg, in_pos_next;
    logic [COUNT_BITS-1:0]        out_count_reg, out_count_next;
    logic [ROW_BITS-1:0]          out_row_reg, out_row_next;
    logic [COL_IDX_BITS-1:0]      out_col_reg, out_col_next;
    logic [NBR_IDX_BITS-1:0]      nbr_idx_reg, nbr_idx_next;
    logic [NBR_CNT_BITS-1:0]      nbr_cnt_reg, nbr_cnt_next;
    logic signed [SUM_BITS-1:0]   sum_reg, sum_next;
    logic signed [CELL_BITS-1:0]  centre_reg, centre_next;
    logic signed [CELL_BITS-1:0]  res_value_reg, res_value_next;
    logic                         res_filled_reg, res_filled_next;
    logic                         out_valid_reg, out_valid_next;
    logic signed [CELL_BITS-1:0]  out_value_reg, out_value_next;
    logic                         out_filled_reg, out_filled_next;
    logic                         out_last_reg, out_last_next;

    logic                         in_fire;
    logic                         full;
    logic                         do_write;
    logic                         emit_now;
    logic [COUNT_BITS:0]          emit_thresh;
    logic                         last_out;
    logic                         col_wrap;

    logic                         ram_we;
    logic [STORE_ADDR_BITS-1:0]   ram_waddr;
    logic [CELL_BITS-1:0]         ram_wdata;
    logic                         ram_re;
    logic [STORE_ADDR_BITS-1:0]   ram_raddr;
    logic [CELL_BITS-1:0]         ram_rdata;
    logic signed [CELL_BITS-1:0]  rd_cell;

    nbr_dir_t                     dir;
    logic [STORE_ADDR_BITS-1:0]   addr_base;
    logic [STORE_ADDR_BITS-1:0]   addr_row;
    logic [STORE_ADDR_BITS-1:0]   nbr_addr;
    logic [STORE_ADDR_BITS-1:0]   col_step;
    logic                         nbr_in_grid;

    logic                         div_start;
    logic                         div_done;
    logic [SUM_BITS-1:0]          div_mag;
    logic [CELL_BITS-1:0]         div_q;
    logic                         sum_neg;
    logic signed [CELL_BITS-1:0]  fill_value;

    ndf_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ndf_store_ram #(
        .ADDR_BITS (STORE_ADDR_BITS),
        .DATA_BITS (CELL_BITS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ndf_mean_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_mag),
        .divisor  (nbr_cnt_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Request decode: store the sample unless draining or the frame is complete; decide on a result.
    assign in_fire     = cells.valid && cells.ready;
    assign full        = (in_pos_reg >= cfg.total);
    assign do_write    = in_fire && !cells.drain && !full;
    assign emit_thresh = {1'b0, out_count_reg} + (COUNT_BITS + 1)'(cfg.cols)
                         + (COUNT_BITS + 1)'(1);
    assign emit_now    = in_fire && (do_write ? ({1'b0, in_pos_reg} >= emit_thresh)
                                              : (full && (out_count_reg < cfg.total)));

    assign rd_cell = signed'(ram_rdata);

    // Neighbour address and grid bounds for the current scan index.
    assign dir       = nbr_dir(nbr_idx_reg);
    assign addr_base = out_count_reg[STORE_ADDR_BITS-1:0];
    assign col_step  = STORE_ADDR_BITS'(cfg.cols);
    assign addr_row  = dir.up   ? (addr_base - col_step) :
                       dir.down ? (addr_base + col_step) : addr_base;
    assign nbr_addr  = dir.left  ? (addr_row - STORE_ADDR_BITS'(1)) :
                       dir.right ? (addr_row + STORE_ADDR_BITS'(1)) : addr_row;
    assign nbr_in_grid =
        (!dir.up    || (out_row_reg != '0)) &&
        (!dir.down  || (((ROW_BITS + 1)'(out_row_reg) + (ROW_BITS + 1)'(1))
                        < (ROW_BITS + 1)'(cfg.rows))) &&
        (!dir.left  || (out_col_reg != '0)) &&
        (!dir.right || ((COL_BITS'(out_col_reg) + COL_BITS'(1)) < cfg.cols));

    // Mean sign handling around the unsigned divider.
    assign sum_neg    = sum_reg[SUM_BITS-1];
    assign div_mag    = sum_neg ? unsigned'(-sum_reg) : unsigned'(sum_reg);
    assign fill_value = sum_neg ? signed'(-div_q) : signed'(div_q);

    // Output position bookkeeping.
    assign last_out = ((out_count_reg + COUNT_BITS'(1)) == cfg.total);
    assign col_wrap = ((COL_BITS'(out_col_reg) + COL_BITS'(1)) == cfg.cols);

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        in_pos_next     = in_pos_reg;
        out_count_next  = out_count_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        nbr_idx_next    = nbr_idx_reg;
        nbr_cnt_next    = nbr_cnt_reg;
        sum_next        = sum_reg;
        centre_next     = centre_reg;
        res_value_next  = res_value_reg;
        res_filled_next = res_filled_reg;
        out_value_next  = out_value_reg;
        out_filled_next = out_filled_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        ram_we          = 1'b0;
        ram_waddr       = in_pos_reg[STORE_ADDR_BITS-1:0];
        ram_wdata       = unsigned'(sext_cell(cells.sample));
        ram_re          = 1'b0;
        ram_raddr       = nbr_addr;
        div_start       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (do_write)
                begin
                    ram_we      = 1'b1;
                    in_pos_next = in_pos_reg + COUNT_BITS'(1);
                end
                if (emit_now)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = addr_base;
                    state_next = S_CTR;
                end
            end

            S_CTR:
            begin
                centre_next = rd_cell;
                if (rd_cell != cfg.nodata)
                begin
                    res_value_next  = rd_cell;
                    res_filled_next = 1'b0;
                    state_next      = S_OUT;
                end
                else
                begin
                    sum_next     = '0;
                    nbr_cnt_next = '0;
                    nbr_idx_next = '0;
                    state_next   = S_NRD;
                end
            end

            S_NRD:
            begin
                if (nbr_in_grid)
                begin
                    ram_re     = 1'b1;
                    state_next = S_NEV;
                end
                else if (nbr_idx_reg == NBR_LAST)
                    state_next = S_FIN;
                else
                    nbr_idx_next = nbr_idx_reg + NBR_IDX_BITS'(1);
            end

            S_NEV:
            begin
                if (rd_cell != cfg.nodata)
                begin
                    sum_next     = sum_reg + SUM_BITS'(rd_cell);
                    nbr_cnt_next = nbr_cnt_reg + NBR_CNT_BITS'(1);
                end
                if (nbr_idx_reg == NBR_LAST)
                    state_next = S_FIN;
                else
                begin
                    nbr_idx_next = nbr_idx_reg + NBR_IDX_BITS'(1);
                    state_next   = S_NRD;
                end
            end

            S_FIN:
            begin
                if (nbr_cnt_reg != '0)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    res_value_next  = centre_reg;
                    res_filled_next = 1'b0;
                    state_next      = S_OUT;
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    // Fill in place so that later cells see the filled value.
                    ram_we          = 1'b1;
                    ram_waddr       = addr_base;
                    ram_wdata       = unsigned'(fill_value);
                    res_value_next  = fill_value;
                    res_filled_next = 1'b1;
                    state_next      = S_OUT;
                end
            end

            S_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_value_reg;
                    out_filled_next = res_filled_reg;
                    out_last_next   = last_out;
                    if (last_out)
                    begin
                        out_count_next = '0;
                        in_pos_next    = '0;
                        out_row_next   = '0;
                        out_col_next   = '0;
                    end
                    else
                    begin
                        out_count_next = out_count_reg + COUNT_BITS'(1);
                        if (col_wrap)
                        begin
                            out_col_next = '0;
                            out_row_next = out_row_reg + ROW_BITS'(1);
                        end
                        else
                            out_col_next = out_col_reg + COL_IDX_BITS'(1);
                    end
                    state_next = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase

        // A geometry write abandons the current frame.
        if (cfg.geom_wr)
        begin
            in_pos_next    = '0;
            out_count_next = '0;
            out_row_next   = '0;
            out_col_next   = '0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_pos_reg    <= '0;
            out_count_reg <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            nbr_idx_reg   <= '0;
            nbr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_pos_reg    <= in_pos_next;
            out_count_reg <= out_count_next;
            out_row_reg   <= out_row_next;
            out_col_reg   <= out_col_next;
            nbr_idx_reg   <= nbr_idx_next;
            nbr_cnt_reg   <= nbr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        sum_reg        <= sum_next;
        centre_reg     <= centre_next;
        res_value_reg  <= res_value_next;
        res_filled_reg <= res_filled_next;
        out_value_reg  <= out_value_next;
        out_filled_reg <= out_filled_next;
        out_last_reg   <= out_last_next;
    end

    assign cells.ready       = (state_reg == S_IDLE);
    assign result.valid      = out_valid_reg;
    assign result.value      = out_value_reg;
    assign result.was_filled = out_filled_reg;
    assign result.last_cell  = out_last_reg;

endmodule
